// File: sv/caf_pkg.sv
package caf_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int SQRT_ITERS       = 24;
	localparam int CNT_W            = $clog2(SQRT_ITERS);
	localparam int IDX_W            = 2;
	localparam int CFG_W            = 17;

	localparam logic [20:0] GYRO_K = 21'd984334;

	localparam logic [IDX_W-1:0] REG_BLEND_WEIGHT = 2'd0;
	localparam logic [IDX_W-1:0] REG_MAX_INTERVAL = 2'd1;

	localparam logic [16:0] WEIGHT_ONE  = 17'd65536;
	localparam logic [16:0] WEIGHT_RST  = 17'd64225;
	localparam logic [15:0] MAX_IV_RST  = 16'd20000;

	typedef struct packed {
		logic [31:0]        timestamp_us;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [19:0] rate_roll;
		logic signed [19:0] rate_pitch;
	} in_item_t;

	typedef struct packed {
		logic signed [19:0] roll_angle;
		logic signed [19:0] pitch_angle;
	} out_item_t;

	typedef enum logic [2:0] {
		MOP_GYRO,
		MOP_LO,
		MOP_STEP,
		MOP_WGYRO,
		MOP_WACC,
		MOP_SUM
	} mul_op_t;

	typedef struct packed {
		logic             ld_in;
		logic             init_a;
		logic             init_b;
		logic             cordic_en;
		logic             sqrt_en;
		logic             mul_en;
		logic             axis;
		mul_op_t          mop;
		logic [CNT_W-1:0] idx;
		logic             load_out;
	} cmd_t;

	typedef struct packed {
		logic in_ok;
	} stat_t;

	// arctan(2^-i) in Q16 degrees
	function automatic logic [21:0] atan_tab(input logic [CNT_W-1:0] i);
		logic [21:0] r;
		case (i)
			5'd0:  r = 22'd2949120;
			5'd1:  r = 22'd1740967;
			5'd2:  r = 22'd919879;
			5'd3:  r = 22'd466945;
			5'd4:  r = 22'd234379;
			5'd5:  r = 22'd117304;
			5'd6:  r = 22'd58666;
			5'd7:  r = 22'd29335;
			5'd8:  r = 22'd14668;
			5'd9:  r = 22'd7334;
			5'd10: r = 22'd3667;
			5'd11: r = 22'd1833;
			5'd12: r = 22'd917;
			5'd13: r = 22'd458;
			5'd14: r = 22'd229;
			5'd15: r = 22'd115;
			5'd16: r = 22'd57;
			5'd17: r = 22'd29;
			5'd18: r = 22'd14;
			5'd19: r = 22'd7;
			5'd20: r = 22'd4;
			5'd21: r = 22'd2;
			5'd22: r = 22'd1;
			default: r = 22'd0;
		endcase
		return r;
	endfunction

endpackage

// File: sv/caf_dp.sv
module caf_dp import caf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  in_item_t         in_data,
	input  cmd_t             cmd,
	output stat_t            stat,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output out_item_t        out_data
);

	logic [16:0]        weight_q;
	logic [15:0]        max_iv_q;
	logic [31:0]        ts_prev_q;
	logic signed [19:0] roll_q, pitch_q;

	logic [15:0]        interval_q;
	logic signed [15:0] ax_q, ay_q, az_q;
	logic signed [19:0] rr_q, rp_q;
	logic [30:0]        sqy_q;

	logic [47:0]        n_q, res_q, bit_q;
	logic signed [39:0] cx_q, cy_q;
	logic signed [25:0] cz_q;
	logic               czero_q;
	logic signed [16:0] acc_roll_q;

	logic signed [36:0] p_q;
	logic [38:0]        lo_q;
	logic signed [17:0] step_q;
	logic signed [39:0] prod1_q, prod2_q;
	out_item_t          out_q;

	// interval check
	logic [31:0] ival_w;
	assign ival_w = in_data.timestamp_us - ts_prev_q;
	assign stat.in_ok = (ival_w != 32'd0) && (ival_w <= {16'd0, max_iv_q});

	logic signed [31:0] sq_in_w, sq_z_w;
	assign sq_in_w = in_data.accel_y * in_data.accel_y;
	assign sq_z_w  = az_q * az_q;

	// square root step
	logic [47:0] trial_w;
	assign trial_w = res_q + bit_q;

	// CORDIC load operands
	logic signed [16:0] negax_w;
	logic signed [39:0] ix_w, iy_w, px_w, py_w;
	logic signed [25:0] pz_w;
	logic               izero_w;
	always_comb begin
		negax_w = -$signed({ax_q[15], ax_q});
		if (cmd.init_b) begin
			iy_w    = $signed({{3{negax_w[16]}}, negax_w, 20'd0});
			ix_w    = $signed({3'd0, res_q[24:0], 12'd0});
			izero_w = (ax_q == 16'sd0) && (res_q == 48'd0);
		end else begin
			iy_w    = $signed({{4{ay_q[15]}}, ay_q, 20'd0});
			ix_w    = $signed({{4{az_q[15]}}, az_q, 20'd0});
			izero_w = (ay_q == 16'sd0) && (az_q == 16'sd0);
		end
		px_w = ix_w;
		py_w = iy_w;
		pz_w = 26'sd0;
		if (ix_w < 0) begin
			if (iy_w >= 0) begin
				px_w = iy_w;
				py_w = -ix_w;
				pz_w = 26'sd5898240;
			end else begin
				px_w = -iy_w;
				py_w = ix_w;
				pz_w = -26'sd5898240;
			end
		end
	end

	logic signed [39:0] sx_w, sy_w;
	logic signed [25:0] tab_w;
	assign sx_w  = cx_q >>> cmd.idx;
	assign sy_w  = cy_q >>> cmd.idx;
	assign tab_w = $signed({4'd0, atan_tab(cmd.idx)});

	logic signed [25:0] zr_w;
	logic signed [16:0] acc_now_w;
	assign zr_w      = (cz_q + 26'sd128) >>> 8;
	assign acc_now_w = czero_q ? 17'sd0 : zr_w[16:0];

	// blend arithmetic
	logic [16:0]        a_w, wc_w;
	logic signed [19:0] rate_w, est_w;
	logic signed [16:0] acc_w;
	logic signed [36:0] p_w;
	logic signed [39:0] hi_w;
	logic signed [57:0] tot_w;
	logic signed [20:0] s_w;
	logic signed [40:0] sum_w;
	logic signed [24:0] v_w;
	logic signed [19:0] sat_w;
	always_comb begin
		a_w    = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;
		wc_w   = WEIGHT_ONE - a_w;
		rate_w = cmd.axis ? rp_q : rr_q;
		est_w  = cmd.axis ? pitch_q : roll_q;
		acc_w  = cmd.axis ? acc_now_w : acc_roll_q;
		p_w    = rate_w * $signed({1'b0, interval_q});
		hi_w   = $signed(p_q[36:18]) * $signed({1'b0, GYRO_K});
		tot_w  = ($signed({{18{hi_w[39]}}, hi_w}) <<< 18) + $signed({19'd0, lo_q})
			+ (58'sd1 <<< 39);
		s_w    = est_w + step_q;
		sum_w  = prod1_q + prod2_q + 41'sd32768;
		v_w    = sum_w[40:16];
		if (v_w > 25'sd524287)
			sat_w = 20'sd524287;
		else if (v_w < -25'sd524288)
			sat_w = -20'sd524288;
		else
			sat_w = v_w[19:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q  <= WEIGHT_RST;
			max_iv_q  <= MAX_IV_RST;
			ts_prev_q <= '0;
			roll_q    <= '0;
			pitch_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BLEND_WEIGHT: weight_q <= cfg_data;
					REG_MAX_INTERVAL: max_iv_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (cmd.ld_in)
				ts_prev_q <= in_data.timestamp_us;
			if (cmd.mul_en && cmd.mop == MOP_SUM) begin
				if (cmd.axis)
					pitch_q <= sat_w;
				else
					roll_q <= sat_w;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			interval_q <= ival_w[15:0];
			ax_q       <= in_data.accel_x;
			ay_q       <= in_data.accel_y;
			az_q       <= in_data.accel_z;
			rr_q       <= in_data.rate_roll;
			rp_q       <= in_data.rate_pitch;
			sqy_q      <= sq_in_w[30:0];
		end
		if (cmd.init_a) begin
			n_q   <= {({1'b0, sqy_q} + {1'b0, sq_z_w[30:0]}), 16'd0};
			res_q <= '0;
			bit_q <= 48'd1 << 46;
		end else if (cmd.sqrt_en) begin
			if (n_q >= trial_w) begin
				n_q   <= n_q - trial_w;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.init_a || cmd.init_b) begin
			cx_q    <= px_w;
			cy_q    <= py_w;
			cz_q    <= pz_w;
			czero_q <= izero_w;
		end else if (cmd.cordic_en) begin
			if (cy_q >= 0) begin
				cx_q <= cx_q + sy_w;
				cy_q <= cy_q - sx_w;
				cz_q <= cz_q + tab_w;
			end else begin
				cx_q <= cx_q - sy_w;
				cy_q <= cy_q + sx_w;
				cz_q <= cz_q - tab_w;
			end
		end
		if (cmd.init_b)
			acc_roll_q <= acc_now_w;
		if (cmd.mul_en) begin
			case (cmd.mop)
				MOP_GYRO:  p_q     <= p_w;
				MOP_LO:    lo_q    <= 39'(p_q[17:0]) * 39'(GYRO_K);
				MOP_STEP:  step_q  <= tot_w[57:40];
				MOP_WGYRO: prod1_q <= $signed({1'b0, a_w}) * s_w;
				MOP_WACC:  prod2_q <= $signed({1'b0, wc_w}) * acc_w;
				default: ;
			endcase
		end
		if (cmd.load_out) begin
			out_q.roll_angle  <= roll_q;
			out_q.pitch_angle <= pitch_q;
		end
	end

	assign out_data = out_q;

endmodule

// File: sv/caf_ctrl.sv
module caf_ctrl import caf_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	output logic  out_valid,
	input  logic  out_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INIT_A,
		S_RUN_A,
		S_INIT_B,
		S_RUN_B,
		S_MUL,
		S_OUT
	} state_t;

	localparam logic [CNT_W-1:0] CNT_LAST_A = CNT_W'(SQRT_ITERS - 1);
	localparam logic [CNT_W-1:0] CNT_LAST_B = CNT_W'(CORDIC_STEPS - 1);
	localparam logic [CNT_W-1:0] CNT_STEPS  = CNT_W'(CORDIC_STEPS);

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             axis_q;
	mul_op_t          mop_q;
	logic             out_valid_q;

	logic accept_w, out_free_w;
	assign in_stall   = (state_q != S_IDLE);
	assign accept_w   = in_valid && !in_stall;
	assign out_free_w = !out_valid_q || !out_stall;
	assign out_valid  = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.mop       = mop_q;
		cmd.axis      = axis_q;
		cmd.idx       = cnt_q;
		cmd.ld_in     = accept_w;
		cmd.init_a    = (state_q == S_INIT_A);
		cmd.init_b    = (state_q == S_INIT_B);
		cmd.sqrt_en   = (state_q == S_RUN_A);
		cmd.cordic_en = ((state_q == S_RUN_A) && (cnt_q < CNT_STEPS)) || (state_q == S_RUN_B);
		cmd.mul_en    = (state_q == S_MUL);
		cmd.load_out  = (state_q == S_OUT) && out_free_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			axis_q      <= 1'b0;
			mop_q       <= MOP_GYRO;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_OUT) && out_free_w)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept_w && stat.in_ok)
						state_q <= S_INIT_A;
				end
				S_INIT_A: begin
					cnt_q   <= '0;
					state_q <= S_RUN_A;
				end
				S_RUN_A: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST_A)
						state_q <= S_INIT_B;
				end
				S_INIT_B: begin
					cnt_q   <= '0;
					state_q <= S_RUN_B;
				end
				S_RUN_B: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST_B) begin
						axis_q  <= 1'b0;
						mop_q   <= MOP_GYRO;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					case (mop_q)
						MOP_GYRO:  mop_q <= MOP_LO;
						MOP_LO:    mop_q <= MOP_STEP;
						MOP_STEP:  mop_q <= MOP_WGYRO;
						MOP_WGYRO: mop_q <= MOP_WACC;
						MOP_WACC:  mop_q <= MOP_SUM;
						default: begin
							mop_q <= MOP_GYRO;
							if (axis_q)
								state_q <= S_OUT;
							else
								axis_q <= 1'b1;
						end
					endcase
				end
				S_OUT: begin
					if (out_free_w)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a new result never overwrites one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("loaded result not presented");

	a_reject_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept_w && !stat.in_ok) |=> (state_q == S_IDLE))
		else $error("rejected beat started work");

	a_run_b_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN_B) |-> (cnt_q < CNT_STEPS))
		else $error("CORDIC step count overrun");

endmodule

// File: sv/complementary_attitude_filter.sv
// Sequence from input beat to result: accept, root and roll-CORDIC load, root run
//   (roll CORDIC alongside), pitch-CORDIC load, pitch CORDIC run, blend products
//   for roll then pitch, output load; a rejected beat finishes in its accept cycle.
//   The 24-step root unit and the shared CORDIC unit (roll, then pitch) serve one
//   beat at a time: input stays stalled until its result is loaded, and a waiting result holds the next one in S_OUT.
// Reset (arst_n low, asynchronous): estimates and last timestamp cleared,
//   blend_weight 64225, max_interval_us 20000, no result pending.
module complementary_attitude_filter import caf_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	caf_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	caf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (out_data)
	);

endmodule
